@@ hw/rtl/vdvs_pkg.sv @@
// Shared types, constants and ROM helper for the liquid-sample scaler.
// Used by vdvs_cfg, vdvs_ln and vil_to_digital_vil_scaler_top.
package vdvs_pkg;

    // Default parameter values
    localparam int FRAC_BITS_DEF       = 8;
    localparam int LOG_TABLE_DEPTH_DEF = 64;

    // Field and port widths
    localparam int VIL_W       = 24;
    localparam int OUT_W       = 18;
    localparam int TDATA_IN_W  = 24;
    localparam int TDATA_OUT_W = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    // Log datapath
    localparam int LOG_Q     = 16;
    localparam int MANT_BITS = 23;
    localparam int LOD_W     = 5;
    localparam int L2_W      = 22;
    localparam int LN_W      = 22;
    localparam int LN_LAT    = 7;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    // Output limits
    localparam int CAP_INT = 253;
    localparam int OUT_MIN = -131072;
    localparam int OUT_MAX = 131071;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_THRESH    = 3'd0,
        CFG_HIGH_THRESH   = 3'd1,
        CFG_LINEAR_OFFSET = 3'd2,
        CFG_LINEAR_GAIN   = 3'd3,
        CFG_LOG_OFFSET    = 3'd4,
        CFG_LOG_GAIN      = 3'd5
    } t_cfg_idx;

    // Branch taken by a sample
    typedef enum logic [1:0] {
        BR_ZERO = 2'd0,
        BR_LIN  = 2'd1,
        BR_LOG  = 2'd2
    } t_branch;

    // Register file contents
    typedef struct packed {
        logic        [23:0] low_thresh;
        logic        [23:0] high_thresh;
        logic signed [15:0] linear_offset;
        logic signed [15:0] linear_gain;
        logic signed [17:0] log_offset;
        logic signed [15:0] log_gain;
    } t_cfg;

    // log2(x0 / 2^30) fraction in Q.16 by repeated squaring, x0 in [1,2) as Q1.30
    function automatic logic [LOG_Q:0] log2_entry(input logic [63:0] x0);
        logic [63:0]    x;
        logic [LOG_Q:0] y;
        x = x0;
        y = '0;
        for (int k = 1; k <= LOG_Q; k++) begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30)) begin
                x = x >> 1;
                y[LOG_Q-k] = 1'b1;
            end
        end
        return y;
    endfunction

endpackage

@@ hw/rtl/vdvs_cfg.sv @@
// Configuration register file for the scaler.
// Depends on vdvs_pkg for the register index codes and the t_cfg struct.
module vdvs_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [vdvs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vdvs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output vdvs_pkg::t_cfg                     o_cfg
);

    vdvs_pkg::t_cfg r_cfg;
    vdvs_pkg::t_cfg n_cfg;

    // Take writes only out of reset
    assign o_cfg_ready = i_rst_n;
    assign o_cfg       = r_cfg;

    // Decode the write, ignore unknown indexes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (vdvs_pkg::t_cfg_idx'(i_cfg_index))
                vdvs_pkg::CFG_LOW_THRESH:    n_cfg.low_thresh    = i_cfg_data[23:0];
                vdvs_pkg::CFG_HIGH_THRESH:   n_cfg.high_thresh   = i_cfg_data[23:0];
                vdvs_pkg::CFG_LINEAR_OFFSET: n_cfg.linear_offset = i_cfg_data[15:0];
                vdvs_pkg::CFG_LINEAR_GAIN:   n_cfg.linear_gain   = i_cfg_data[15:0];
                vdvs_pkg::CFG_LOG_OFFSET:    n_cfg.log_offset    = i_cfg_data[17:0];
                vdvs_pkg::CFG_LOG_GAIN:      n_cfg.log_gain      = i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ hw/rtl/vdvs_ln.sv @@
// Pipelined natural log of a Q.F sample: leading-one detect, normalize,
// log2 table with interpolation, scale by ln(2). Depends on vdvs_pkg.
module vdvs_ln #(
    parameter int FRAC_BITS       = vdvs_pkg::FRAC_BITS_DEF,
    parameter int LOG_TABLE_DEPTH = vdvs_pkg::LOG_TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [vdvs_pkg::VIL_W-1:0]          i_value,
    output logic signed [vdvs_pkg::LN_W-1:0]    o_ln
);

    localparam int VW   = vdvs_pkg::VIL_W;
    localparam int MB   = vdvs_pkg::MANT_BITS;
    localparam int LQ   = vdvs_pkg::LOG_Q;
    localparam int PW_L = vdvs_pkg::LOD_W;
    localparam int L2W  = vdvs_pkg::L2_W;
    localparam int LNW  = vdvs_pkg::LN_W;
    localparam int IW   = $clog2(LOG_TABLE_DEPTH);
    localparam int AW   = $clog2(LOG_TABLE_DEPTH + 1);
    localparam int PW   = MB + IW;
    localparam int PRW  = L2W + 31;
    localparam logic signed [L2W-1:0] F_OFS = L2W'(FRAC_BITS) <<< LQ;
    localparam logic signed [PRW-1:0] RND   = PRW'(1) <<< 29;

    // log2(1 + i/DEPTH) table, built at elaboration
    logic [LQ:0] rom_q [0:LOG_TABLE_DEPTH];

    for (genvar gi = 0; gi < LOG_TABLE_DEPTH; gi++) begin : g_rom
        localparam logic [63:0] X0 = (64'd1 << 30) + ((64'(gi) << 30) / LOG_TABLE_DEPTH);
        assign rom_q[gi] = vdvs_pkg::log2_entry(X0);
    end
    assign rom_q[LOG_TABLE_DEPTH] = (LQ+1)'(1) << LQ;

    // Stage 1: leading-one position
    logic [VW-1:0]   r_v1;
    logic [PW_L-1:0] r_p1;
    logic [PW_L-1:0] n_p1;

    always_comb begin
        n_p1 = '0;
        for (int b = 0; b < VW; b++) begin
            if (i_value[b]) n_p1 = PW_L'(b);
        end
    end

    // Stage 2: left-align bits below the leading one
    logic [MB-1:0]      r_frac2;
    logic [PW_L-1:0]    r_p2;
    logic [VW+MB-1:0]   n_sh2;

    assign n_sh2 = {r_v1, {MB{1'b0}}} >> r_p1;

    // Stage 3: table position and remainder
    logic [IW-1:0]   r_idx3;
    logic [MB-1:0]   r_rem3;
    logic [PW_L-1:0] r_p3;
    logic [PW-1:0]   n_pos3;

    assign n_pos3 = PW'(r_frac2) * PW'(LOG_TABLE_DEPTH);

    // Stage 4: table reads
    logic [LQ:0]     r_lo4;
    logic [LQ:0]     r_diff4;
    logic [MB-1:0]   r_rem4;
    logic [PW_L-1:0] r_p4;
    logic [AW-1:0]   addr_lo;
    logic [AW-1:0]   addr_hi;

    assign addr_lo = AW'(r_idx3);
    assign addr_hi = AW'(r_idx3) + AW'(1);

    // Stage 5: interpolate and form log2 of the real value
    logic signed [L2W-1:0] r_l2_5;
    logic [LQ+MB:0]        n_step5;
    logic [LQ:0]           n_interp5;

    assign n_step5   = (LQ+MB+1)'(r_diff4) * (LQ+MB+1)'(r_rem4);
    assign n_interp5 = r_lo4 + n_step5[LQ+MB:MB];

    // Stage 6: multiply by ln(2)
    logic signed [PRW-1:0] r_prod6;

    // Stage 7: round to Q.16
    logic signed [LNW-1:0] r_ln7;
    logic signed [PRW-1:0] n_rnd7;

    assign n_rnd7 = (r_prod6 + RND) >>> 30;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v1    <= i_value;
            r_p1    <= n_p1;
            r_frac2 <= n_sh2[MB-1:0];
            r_p2    <= r_p1;
            r_idx3  <= n_pos3[PW-1:MB];
            r_rem3  <= n_pos3[MB-1:0];
            r_p3    <= r_p2;
            r_lo4   <= rom_q[addr_lo];
            r_diff4 <= rom_q[addr_hi] - rom_q[addr_lo];
            r_rem4  <= r_rem3;
            r_p4    <= r_p3;
            r_l2_5  <= $signed({1'b0, r_p4, {LQ{1'b0}}}) + $signed(L2W'(n_interp5)) - F_OFS;
            r_prod6 <= PRW'(r_l2_5) * $signed({1'b0, vdvs_pkg::LN2_Q30});
            r_ln7   <= LNW'(n_rnd7);
        end
    end

    assign o_ln = r_ln7;

endmodule

@@ hw/rtl/vil_to_digital_vil_scaler_top.sv @@
// Top level of the liquid-sample scaler: threshold split, linear branch,
// log branch and output register. Depends on vdvs_pkg, vdvs_cfg, vdvs_ln.
//
//  channel  dir  handshake                    payload
//  s_axis   in   s_axis_tvalid/s_axis_tready  tdata: vil_value; tuser: vil_present
//  m_axis   out  m_axis_tvalid/m_axis_tready  tdata: scaled_value; tuser: value_written
//  cfg      in   i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// One word enters per cycle while the pipeline is not frozen; each result leaves
// through the nine register stages of the log branch (table, ln(2), gain).
// The whole pipeline advances together; it freezes while the output holds a
// word that is not taken, and s_axis_tready stays low while it is frozen.
// Reset clears the valid bits and the configuration registers and holds both
// ready outputs low; no clearing pass is needed.
module vil_to_digital_vil_scaler_top #(
    parameter int FRAC_BITS       = vdvs_pkg::FRAC_BITS_DEF,
    parameter int LOG_TABLE_DEPTH = vdvs_pkg::LOG_TABLE_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // slave stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [vdvs_pkg::TDATA_IN_W-1:0]       s_axis_tdata,   // [23:0] vil_value
    input  logic [0:0]                            s_axis_tuser,   // [0] vil_present
    // master stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [vdvs_pkg::TDATA_OUT_W-1:0]      m_axis_tdata,   // [17:0] scaled_value
    output logic [0:0]                            m_axis_tuser,   // [0] value_written
    // configuration write
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [vdvs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [vdvs_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int NST  = vdvs_pkg::LN_LAT + 2;
    localparam int SW   = 48;
    localparam int LAW  = 42;
    localparam int OW   = vdvs_pkg::OUT_W;
    localparam int LQ   = vdvs_pkg::LOG_Q;
    localparam int LNW  = vdvs_pkg::LN_W;
    localparam int LPW  = 16 + LNW;
    localparam logic signed [SW-1:0] CAP_Q = SW'(vdvs_pkg::CAP_INT) <<< FRAC_BITS;
    localparam logic signed [SW-1:0] OMAX  = SW'(vdvs_pkg::OUT_MAX);
    localparam logic signed [SW-1:0] OMIN  = SW'(vdvs_pkg::OUT_MIN);
    localparam logic signed [LAW-1:0] LIN_RND = LAW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SW-1:0]  LOG_RND = SW'(1) <<< (LQ - 1);

    // Cap at 253.0 and saturate into the output field
    function automatic logic signed [OW-1:0] f_sat(input logic signed [SW-1:0] r);
        logic signed [SW-1:0] t;
        t = r;
        if (t > CAP_Q) t = CAP_Q;
        if (t > OMAX)  t = OMAX;
        if (t < OMIN)  t = OMIN;
        return OW'(t);
    endfunction

    vdvs_pkg::t_cfg cfg;

    vdvs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Pipeline advance; hold the input off during reset
    logic r_vld [1:NST];
    logic en;

    assign en            = !r_vld[NST] || m_axis_tready;
    assign s_axis_tready = en && i_rst_n;

    logic [vdvs_pkg::VIL_W-1:0] in_v;
    assign in_v = s_axis_tdata[vdvs_pkg::VIL_W-1:0];

    // Log branch
    logic signed [LNW-1:0] ln7;

    vdvs_ln #(
        .FRAC_BITS       (FRAC_BITS),
        .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
    ) u_ln (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_value (in_v),
        .o_ln    (ln7)
    );

    // Stage 1: branch select and linear product
    vdvs_pkg::t_branch n_br1;
    logic signed [40:0] r_linp1;

    always_comb begin
        if (in_v <= cfg.low_thresh) begin
            n_br1 = vdvs_pkg::BR_ZERO;
        end else if (in_v < cfg.high_thresh) begin
            n_br1 = vdvs_pkg::BR_LIN;
        end else begin
            n_br1 = vdvs_pkg::BR_LOG;
        end
    end

    // Stage 2: linear offset, rounding, cap
    logic signed [LAW-1:0] lin_acc;
    logic signed [LAW-1:0] lin_r;

    assign lin_acc = (LAW'($signed(cfg.linear_offset)) <<< FRAC_BITS) + LAW'(r_linp1);
    assign lin_r   = (lin_acc + LIN_RND) >>> FRAC_BITS;

    // Side data that travels beside the log pipeline
    vdvs_pkg::t_branch     r_br   [1:NST-1];
    logic                  r_pres [1:NST-1];
    logic signed [OW-1:0]  r_lin  [2:NST-1];

    // Stage 8: log gain product
    logic signed [LPW-1:0] r_logp8;

    // Stage 9: log offset, rounding, final select
    logic signed [SW-1:0] log_acc;
    logic signed [SW-1:0] log_r;
    logic signed [OW-1:0] n_res;
    logic [OW-1:0]        r_out_data;
    logic                 r_out_wr;

    assign log_acc = (SW'($signed(cfg.log_offset)) <<< LQ) + SW'(r_logp8);
    assign log_r   = (log_acc + LOG_RND) >>> LQ;

    always_comb begin
        case (r_br[NST-1])
            vdvs_pkg::BR_ZERO: n_res = '0;
            vdvs_pkg::BR_LIN:  n_res = r_lin[NST-1];
            vdvs_pkg::BR_LOG:  n_res = f_sat(log_r);
            default:           n_res = '0;
        endcase
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= NST; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[1] <= s_axis_tvalid;
            for (int k = 2; k <= NST; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_br[1]   <= n_br1;
            r_pres[1] <= s_axis_tuser[0];
            r_linp1   <= $signed(cfg.linear_gain) * $signed({1'b0, in_v});
            r_br[2]   <= r_br[1];
            r_pres[2] <= r_pres[1];
            r_lin[2]  <= f_sat(SW'(lin_r));
            for (int k = 3; k <= NST-1; k++) begin
                r_br[k]   <= r_br[k-1];
                r_pres[k] <= r_pres[k-1];
                r_lin[k]  <= r_lin[k-1];
            end
            r_logp8    <= $signed(cfg.log_gain) * ln7;
            r_out_data <= r_pres[NST-1] ? n_res : '0;
            r_out_wr   <= r_pres[NST-1];
        end
    end

    assign m_axis_tvalid = r_vld[NST];
    assign m_axis_tdata  = {{(vdvs_pkg::TDATA_OUT_W-OW){1'b0}}, r_out_data};
    assign m_axis_tuser  = r_out_wr;

    // Missing samples leave as zero
    a_missing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("missing sample gave a nonzero value");

    // No result exceeds the cap
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> SW'($signed(m_axis_tdata[OW-1:0])) <= CAP_Q)
        else $error("result above cap");

    // A stalled output freezes the pipeline
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NST] && !m_axis_tready |=> r_vld[NST-1] == $past(r_vld[NST-1]))
        else $error("pipeline moved during stall");

    // An output word appears only from an occupied stage before the output register
    a_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_vld[NST-1]))
        else $error("output valid without a source word");

    // Samples at or below the low threshold give zero
    a_zero_branch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_vld[NST-1] && r_br[NST-1] == vdvs_pkg::BR_ZERO |=> m_axis_tdata == '0)
        else $error("zero branch gave a nonzero value");

endmodule

@@ test/tb_vil_to_digital_vil_scaler_top.sv @@
// Self-checking bench for vil_to_digital_vil_scaler_top: a directed table, then random
// phases of register settings and samples, each output word checked against a predictor.
// Depends on vdvs_pkg and the scaler RTL.
`timescale 1ns / 100ps

module tb_vil_to_digital_vil_scaler_top;

    localparam int FRAC_W      = vdvs_pkg::FRAC_BITS_DEF;
    localparam int LOG_DEPTH   = vdvs_pkg::LOG_TABLE_DEPTH_DEF;
    localparam int LN_FRAC     = 16;
    localparam int MANT_W      = 23;
    localparam longint LN2_FIXED = 744261118;   // ln(2) in Q.30
    localparam longint SCALE_CAP = 253 * (1 << FRAC_W);
    localparam longint SAT_MAX   = 131071;
    localparam longint SAT_MIN   = -131072;
    localparam int PIPE_DEPTH  = 9;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 102;
    localparam int REPORT_MAX  = 10;

    // Indexes past the register file; writes there must change nothing
    localparam logic [vdvs_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [vdvs_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    // Largest and most negative value of each register, by index
    localparam logic [23:0] REG_TOP [6] = '{24'hFFFFFF, 24'hFFFFFF, 24'h007FFF,
                                            24'h007FFF, 24'h01FFFF, 24'h007FFF};
    localparam logic [23:0] REG_BOTTOM [6] = '{24'h000000, 24'h000000, 24'h008000,
                                               24'h008000, 24'h020000, 24'h008000};

    typedef struct packed {
        logic signed [17:0] scaled;
        logic               written;
    } t_scaled_word;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_SAMPLE,
        ROW_SAMPLE_KNOWN
    } t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [2:0]         idx;
        logic [23:0]        data;
        logic               present;
        t_scaled_word       want;
    } t_row;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [vdvs_pkg::TDATA_IN_W-1:0]     s_axis_tdata = '0;    // [23:0] vil_value
    logic [0:0]                          s_axis_tuser = '0;    // [0] vil_present
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [vdvs_pkg::TDATA_OUT_W-1:0]    m_axis_tdata;         // [17:0] scaled_value
    logic [0:0]                          m_axis_tuser;         // [0] value_written
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [vdvs_pkg::CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [vdvs_pkg::CFG_DATA_W-1:0]     i_cfg_data = '0;

    vdvs_pkg::t_cfg          cfg_regs = '0;
    longint unsigned         log2_frac_rom [0:LOG_DEPTH];
    t_scaled_word            expected_scaled [$];
    t_scaled_word            seen_word;
    t_scaled_word            due_word;
    t_row                    plan [$];
    logic                    idling_on = 1'b1;
    int                      mismatch_cnt = 0;
    int                      words_seen = 0;

    vil_to_digital_vil_scaler_top #(
        .FRAC_BITS       (FRAC_W),
        .LOG_TABLE_DEPTH (LOG_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Predict the output word of one sample under the current register settings
    function automatic t_scaled_word scale_vil(input logic [23:0] v, input logic present);
        t_scaled_word    res;
        longint          acc, r, interp, l2, ln_val;
        longint unsigned frac, pos, rem;
        int              lead, idx;
        res.written = present;
        r = 0;
        if (present) begin
            if (v <= cfg_regs.low_thresh) begin
                r = 0;
            end else if (v < cfg_regs.high_thresh) begin
                acc = longint'(cfg_regs.linear_offset) * (longint'(1) << FRAC_W)
                    + longint'(cfg_regs.linear_gain) * longint'(v);
                r = (acc + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
            end else begin
                // log2 = leading-one position plus interpolated table fraction
                lead = 0;
                for (int b = 0; b < vdvs_pkg::VIL_W; b++) begin
                    if (v[b]) lead = b;
                end
                frac = (longint'(v) << (MANT_W - lead)) & ((longint'(1) << MANT_W) - 1);
                pos  = frac * LOG_DEPTH;
                idx  = int'(pos >> MANT_W);
                if (idx >= LOG_DEPTH) idx = LOG_DEPTH - 1;
                rem  = pos & ((longint'(1) << MANT_W) - 1);
                interp = longint'(log2_frac_rom[idx])
                       + longint'(((log2_frac_rom[idx + 1] - log2_frac_rom[idx]) * rem)
                                  >> MANT_W);
                if (v == 0) interp = 0;
                l2 = (longint'(lead) << LN_FRAC) + interp - (longint'(FRAC_W) << LN_FRAC);
                ln_val = (l2 * LN2_FIXED + (longint'(1) << 29)) >>> 30;
                acc = longint'(cfg_regs.log_offset) * (longint'(1) << LN_FRAC)
                    + longint'(cfg_regs.log_gain) * ln_val;
                r = (acc + (longint'(1) << (LN_FRAC - 1))) >>> LN_FRAC;
            end
            if (r > SCALE_CAP) r = SCALE_CAP;
            if (r > SAT_MAX) r = SAT_MAX;
            if (r < SAT_MIN) r = SAT_MIN;
        end
        res.scaled = 18'(r);
        return res;
    endfunction

    function automatic t_row wr(input logic [2:0] idx, input logic [23:0] data);
        t_row row;
        row = '{ROW_WRITE, idx, data, 1'b0, '0};
        return row;
    endfunction

    function automatic t_row smp(input logic [23:0] vil, input logic present);
        t_row row;
        row = '{ROW_SAMPLE, '0, vil, present, '0};
        return row;
    endfunction

    function automatic t_row known(input logic [23:0] vil, input logic present,
                                   input logic signed [17:0] scaled, input logic written);
        t_row row;
        row = '{ROW_SAMPLE_KNOWN, '0, vil, present, '{scaled, written}};
        return row;
    endfunction

    // Write one register and mirror it in the predictor's copy
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            vdvs_pkg::CFG_LOW_THRESH:    cfg_regs.low_thresh    = data;
            vdvs_pkg::CFG_HIGH_THRESH:   cfg_regs.high_thresh   = data;
            vdvs_pkg::CFG_LINEAR_OFFSET: cfg_regs.linear_offset = data[15:0];
            vdvs_pkg::CFG_LINEAR_GAIN:   cfg_regs.linear_gain   = data[15:0];
            vdvs_pkg::CFG_LOG_OFFSET:    cfg_regs.log_offset    = data[17:0];
            vdvs_pkg::CFG_LOG_GAIN:      cfg_regs.log_gain      = data[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Offer one sample word, optionally after a gap; record its expected word on accept
    task automatic send_sample(input logic [23:0] vil, input logic present,
                               input logic typed, input t_scaled_word want);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= vil;
        s_axis_tuser  <= present;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_scaled.push_back(typed ? want : scale_vil(vil, present));
        @(negedge i_clk);
    endtask

    // Stop offering samples and let the pipeline empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_scaled.size() != 0) @(negedge i_clk);
        repeat (PIPE_DEPTH + 4) @(negedge i_clk);
    endtask

    // Output side: stall in random bursts while idling is on
    initial begin
        forever begin
            @(negedge i_clk);
            if (idling_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Compare every accepted output word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_word.scaled  = m_axis_tdata[17:0];
            seen_word.written = m_axis_tuser[0];
            words_seen++;
            if (expected_scaled.size() == 0) begin
                if (mismatch_cnt < REPORT_MAX)
                    $display("word %0d: unexpected output scaled=%0d written=%0b",
                             words_seen, seen_word.scaled, seen_word.written);
                mismatch_cnt++;
            end else begin
                due_word = expected_scaled.pop_front();
                if (seen_word.scaled !== due_word.scaled ||
                    seen_word.written !== due_word.written) begin
                    if (mismatch_cnt < REPORT_MAX)
                        $display("word %0d: expected scaled=%0d written=%0b, got %0d %0b",
                                 words_seen, due_word.scaled, due_word.written,
                                 seen_word.scaled, seen_word.written);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb_vil_to_digital_vil_scaler_top: FAIL");
        $finish;
    end

    initial begin
        longint unsigned sq;
        longint unsigned bits;
        logic [23:0]     reg_vals [6];
        logic [23:0]     tmp;
        logic [23:0]     vil;
        int              delta;

        // log2(1 + i/DEPTH) fractions by repeated squaring in Q1.30
        for (int i = 0; i < LOG_DEPTH; i++) begin
            sq   = (longint'(1) << 30) + ((longint'(i) << 30) / LOG_DEPTH);
            bits = 0;
            for (int k = 1; k <= LN_FRAC; k++) begin
                sq = (sq * sq) >> 30;
                if (sq >= (longint'(2) << 30)) begin
                    sq   = sq >> 1;
                    bits = bits | (longint'(1) << (LN_FRAC - k));
                end
            end
            log2_frac_rom[i] = bits;
        end
        log2_frac_rom[LOG_DEPTH] = longint'(1) << LN_FRAC;

        // Directed table: reset values, branch edges, caps, crossed thresholds
        plan.push_back(known(24'h000000, 1'b1, 18'sd0, 1'b1));
        plan.push_back(known(24'hFFFFFF, 1'b0, 18'sd0, 1'b0));
        plan.push_back(known(24'hFFFFFF, 1'b1, 18'sd0, 1'b1));
        plan.push_back(known(24'h000001, 1'b1, 18'sd0, 1'b1));
        plan.push_back(wr(vdvs_pkg::CFG_LOW_THRESH,    24'h000100));
        plan.push_back(wr(vdvs_pkg::CFG_HIGH_THRESH,   24'h010000));
        plan.push_back(wr(vdvs_pkg::CFG_LINEAR_OFFSET, 24'h000100));
        plan.push_back(wr(vdvs_pkg::CFG_LINEAR_GAIN,   24'h000080));
        plan.push_back(wr(vdvs_pkg::CFG_LOG_OFFSET,    24'h000A00));
        plan.push_back(wr(vdvs_pkg::CFG_LOG_GAIN,      24'h000200));
        plan.push_back(known(24'h000100, 1'b1, 18'sd0, 1'b1));
        plan.push_back(smp(24'h000101, 1'b1));
        plan.push_back(smp(24'h00FFFF, 1'b1));
        plan.push_back(smp(24'h010000, 1'b1));
        plan.push_back(smp(24'hFFFFFF, 1'b1));
        plan.push_back(known(24'h000000, 1'b1, 18'sd0, 1'b1));
        plan.push_back(known(24'hABCDEF, 1'b0, 18'sd0, 1'b0));
        // linear branch pinned at the cap, then at the negative rail
        plan.push_back(wr(vdvs_pkg::CFG_LINEAR_OFFSET, 24'h007FFF));
        plan.push_back(wr(vdvs_pkg::CFG_LINEAR_GAIN,   24'h007FFF));
        plan.push_back(known(24'h00FFFF, 1'b1, 18'(SCALE_CAP), 1'b1));
        plan.push_back(wr(vdvs_pkg::CFG_LINEAR_OFFSET, 24'h008000));
        plan.push_back(wr(vdvs_pkg::CFG_LINEAR_GAIN,   24'h008000));
        plan.push_back(known(24'h00FFFF, 1'b1, 18'(SAT_MIN), 1'b1));
        plan.push_back(smp(24'h000101, 1'b1));
        // log branch at both coefficient extremes
        plan.push_back(wr(vdvs_pkg::CFG_LOG_OFFSET,    24'h01FFFF));
        plan.push_back(wr(vdvs_pkg::CFG_LOG_GAIN,      24'h007FFF));
        plan.push_back(known(24'hFFFFFF, 1'b1, 18'(SCALE_CAP), 1'b1));
        plan.push_back(smp(24'h010000, 1'b1));
        plan.push_back(wr(vdvs_pkg::CFG_LOG_OFFSET,    24'h020000));
        plan.push_back(wr(vdvs_pkg::CFG_LOG_GAIN,      24'h008000));
        plan.push_back(known(24'hFFFFFF, 1'b1, 18'(SAT_MIN), 1'b1));
        plan.push_back(smp(24'h010000, 1'b1));
        // high threshold below low: low test wins, above it goes to the log branch
        plan.push_back(wr(vdvs_pkg::CFG_LOW_THRESH,    24'h100000));
        plan.push_back(wr(vdvs_pkg::CFG_HIGH_THRESH,   24'h000010));
        plan.push_back(wr(vdvs_pkg::CFG_LOG_OFFSET,    24'h000000));
        plan.push_back(wr(vdvs_pkg::CFG_LOG_GAIN,      24'h000100));
        plan.push_back(known(24'h000010, 1'b1, 18'sd0, 1'b1));
        plan.push_back(known(24'h100000, 1'b1, 18'sd0, 1'b1));
        plan.push_back(smp(24'h100001, 1'b1));
        // writes past the register file are dropped
        plan.push_back(wr(CFG_SPARE_A,                 24'hFFFFFF));
        plan.push_back(wr(CFG_SPARE_B,                 24'hFFFFFF));
        plan.push_back(smp(24'hFFFFFF, 1'b1));
        // tiny samples give a negative log
        plan.push_back(wr(vdvs_pkg::CFG_LOW_THRESH,    24'h000000));
        plan.push_back(wr(vdvs_pkg::CFG_HIGH_THRESH,   24'h000000));
        plan.push_back(smp(24'h000001, 1'b1));
        plan.push_back(smp(24'h000080, 1'b1));
        plan.push_back(smp(24'h800000, 1'b1));

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table
        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_WRITE: begin
                    drain();
                    write_reg(plan[i].idx, plan[i].data);
                end
                ROW_SAMPLE: send_sample(plan[i].data, plan[i].present, 1'b0, '0);
                default:    send_sample(plan[i].data, plan[i].present, 1'b1, plan[i].want);
            endcase
        end

        // Random phases: new settings, then a run of samples aimed at the branch edges
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            idling_on <= (ph != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (int r = 0; r < 6; r++) begin
                case ($urandom_range(0, 6))
                    0: reg_vals[r] = '0;
                    1: reg_vals[r] = REG_TOP[r];
                    2: reg_vals[r] = REG_BOTTOM[r];
                    3: reg_vals[r] = 24'($urandom());
                    default: begin
                        if (r <= int'(vdvs_pkg::CFG_HIGH_THRESH))
                            reg_vals[r] = 24'($urandom() >> $urandom_range(8, 20));
                        else
                            reg_vals[r] = 24'(int'($urandom_range(0, 2047)) - 1024);
                    end
                endcase
            end
            // keep the linear window open most of the time
            if (reg_vals[vdvs_pkg::CFG_LOW_THRESH] > reg_vals[vdvs_pkg::CFG_HIGH_THRESH] &&
                $urandom_range(0, 3) != 0) begin
                tmp = reg_vals[vdvs_pkg::CFG_LOW_THRESH];
                reg_vals[vdvs_pkg::CFG_LOW_THRESH]  = reg_vals[vdvs_pkg::CFG_HIGH_THRESH];
                reg_vals[vdvs_pkg::CFG_HIGH_THRESH] = tmp;
            end
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 24'($urandom()));
            for (int r = 0; r < 6; r++)
                write_reg(3'(r), reg_vals[r]);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                delta = int'($urandom_range(0, 6)) - 3;
                case ($urandom_range(0, 7))
                    0: vil = 24'($urandom());
                    1: vil = 24'(int'(cfg_regs.low_thresh) + delta);
                    2: vil = 24'(int'(cfg_regs.high_thresh) + delta);
                    3: begin
                        if (cfg_regs.high_thresh > cfg_regs.low_thresh + 1)
                            vil = 24'($urandom_range(cfg_regs.low_thresh + 1,
                                                     cfg_regs.high_thresh - 1));
                        else
                            vil = 24'($urandom());
                    end
                    4: vil = 24'($urandom_range(cfg_regs.high_thresh, 24'hFFFFFF));
                    5: vil = 24'($urandom_range(0, 511));
                    6: vil = 24'($urandom() >> $urandom_range(8, 31));
                    default: vil = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
                endcase
                send_sample(vil, $urandom_range(0, 9) != 0, 1'b0, '0);
            end
        end

        drain();
        if (mismatch_cnt == 0 && expected_scaled.size() == 0) begin
            $display("tb_vil_to_digital_vil_scaler_top: PASS");
        end else begin
            $display("tb_vil_to_digital_vil_scaler_top: FAIL");
        end
        $finish;
    end

endmodule

@@ vil_to_digital_vil_scaler_top.f @@
hw/rtl/vdvs_pkg.sv
hw/rtl/vdvs_cfg.sv
hw/rtl/vdvs_ln.sv
hw/rtl/vil_to_digital_vil_scaler_top.sv
test/tb_vil_to_digital_vil_scaler_top.sv
